[rtl/apsp_pkg.sv]
`default_nettype none

package apsp_pkg;

	// parser phase codes
	localparam logic [3:0] PH_START  = 4'd0;
	localparam logic [3:0] PH_V      = 4'd1;
	localparam logic [3:0] PH_C      = 4'd2;
	localparam logic [3:0] PH_CA     = 4'd3;
	localparam logic [3:0] PH_VFIRST = 4'd4;
	localparam logic [3:0] PH_VWS    = 4'd5;
	localparam logic [3:0] PH_VSIGN  = 4'd6;
	localparam logic [3:0] PH_VDIG   = 4'd7;
	localparam logic [3:0] PH_VDONE  = 4'd8;
	localparam logic [3:0] PH_CFIRST = 4'd9;
	localparam logic [3:0] PH_CVAL   = 4'd10;
	localparam logic [3:0] PH_AFIRST = 4'd11;
	localparam logic [3:0] PH_AVAL   = 4'd12;
	localparam logic [3:0] PH_SKIP   = 4'd13;

	// characters of interest
	localparam logic [7:0] CH_COMMA = 8'd44;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_V     = 8'd118;
	localparam logic [7:0] CH_C     = 8'd99;
	localparam logic [7:0] CH_A     = 8'd97;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	// result kinds, also used as emitter section codes
	localparam logic [1:0] KIND_VER    = 2'd0;
	localparam logic [1:0] KIND_CRYPTO = 2'd1;
	localparam logic [1:0] KIND_CA     = 2'd2;

	// string store write strobes
	typedef struct packed {
		logic crypto;
		logic ca;
	} wr_en_t;

	// end of string hand-over from parser to emitter
	typedef struct packed {
		logic        go;
		logic [31:0] value;
		logic        neg;
		logic        ovf;
	} run_start_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

`default_nettype wire

[rtl/apsp_ram.sv]
`default_nettype none

module apsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read that holds while not enabled
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/apsp_parser.sv]
`default_nettype none

module apsp_parser
	import apsp_pkg::*;
#(
	parameter int CRYPTO_CAP = 16,
	parameter int CA_CAP = 48,
	localparam int CLEN_W = (CRYPTO_CAP > 1) ? $clog2(CRYPTO_CAP) : 1,
	localparam int ALEN_W = (CA_CAP > 1) ? $clog2(CA_CAP) : 1,
	localparam int C_DEPTH = (CRYPTO_CAP > 1) ? CRYPTO_CAP - 1 : 1,
	localparam int A_DEPTH = (CA_CAP > 1) ? CA_CAP - 1 : 1,
	localparam int C_AW = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1,
	localparam int A_AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        ch,
	input  wire logic              has_char,
	input  wire logic              last,
	input  wire logic              busy,
	output wr_en_t                 wr,
	output logic      [C_AW-1:0]   c_waddr,
	output logic      [A_AW-1:0]   a_waddr,
	output logic      [7:0]        wdata,
	output run_start_t             run,
	output logic      [CLEN_W-1:0] run_clen,
	output logic      [ALEN_W-1:0] run_alen
);

	localparam logic [CLEN_W-1:0] C_LIM = CLEN_W'(CRYPTO_CAP - 1);
	localparam logic [ALEN_W-1:0] A_LIM = ALEN_W'(CA_CAP - 1);

	logic              valid_s1;
	logic [7:0]        ch_s1;
	logic              has_char_s1;
	logic              last_s1;
	logic              in_xfer;
	logic              proc;
	logic              eos;

	logic [3:0]        phase_q, phase_d;
	logic [31:0]       ver_q, ver_d;
	logic              neg_q, neg_d;
	logic              ovf_q, ovf_d;
	logic [CLEN_W-1:0] clen_q, clen_d;
	logic [ALEN_W-1:0] alen_q, alen_d;

	logic              v_first;
	logic              v_ws;
	logic [31:0]       v_base;
	logic [35:0]       acc;
	logic [CLEN_W-1:0] c_base;
	logic [ALEN_W-1:0] a_base;

	// no new transfer while an end of string is pending or a run is being read out
	assign in_stall = (valid_s1 && last_s1) || busy;
	assign in_xfer  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_s1       <= ch;
			has_char_s1 <= has_char;
			last_s1     <= last;
		end
	end

	assign proc = valid_s1 && has_char_s1;
	assign eos  = valid_s1 && last_s1;

	// version accumulator: base * 10 + digit
	assign v_first = (phase_q == PH_VFIRST);
	assign v_ws    = v_first || (phase_q == PH_VWS);
	assign v_base  = v_first ? 32'd0 : ver_q;
	assign acc     = {1'b0, v_base, 3'b000} + {3'b000, v_base, 1'b0} + {32'd0, ch_s1[3:0]};

	// string write positions
	assign c_base  = (phase_q == PH_CFIRST) ? '0 : clen_q;
	assign a_base  = (phase_q == PH_AFIRST) ? '0 : alen_q;
	assign c_waddr = c_base[C_AW-1:0];
	assign a_waddr = a_base[A_AW-1:0];
	assign wdata   = ch_s1;

	// field parser next state
	always_comb begin
		phase_d = phase_q;
		ver_d   = ver_q;
		neg_d   = neg_q;
		ovf_d   = ovf_q;
		clen_d  = clen_q;
		alen_d  = alen_q;
		wr      = '0;
		if (proc) begin
			if (ch_s1 == CH_COMMA) begin
				phase_d = PH_START;
			end else begin
				unique case (phase_q)
					PH_START: begin
						phase_d = (ch_s1 == CH_V) ? PH_V :
							(ch_s1 == CH_C) ? PH_C : PH_SKIP;
					end
					PH_V: begin
						phase_d = (ch_s1 == CH_COLON) ? PH_VFIRST : PH_SKIP;
					end
					PH_C: begin
						phase_d = (ch_s1 == CH_COLON) ? PH_CFIRST :
							(ch_s1 == CH_A) ? PH_CA : PH_SKIP;
					end
					PH_CA: begin
						phase_d = (ch_s1 == CH_COLON) ? PH_AFIRST : PH_SKIP;
					end
					PH_VFIRST, PH_VWS, PH_VSIGN, PH_VDIG: begin
						if (v_first) begin
							ver_d = 32'd0;
							neg_d = 1'b0;
							ovf_d = 1'b0;
						end
						if (v_ws && is_blank(ch_s1)) begin
							phase_d = PH_VWS;
						end else if (v_ws && (ch_s1 == CH_PLUS || ch_s1 == CH_MINUS)) begin
							neg_d   = (ch_s1 == CH_MINUS);
							phase_d = PH_VSIGN;
						end else if (is_digit(ch_s1)) begin
							ver_d   = (acc[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc[31:0];
							ovf_d   = ovf_d || (acc[35:32] != 4'd0);
							phase_d = PH_VDIG;
						end else begin
							phase_d = PH_VDONE;
						end
					end
					PH_CFIRST, PH_CVAL: begin
						phase_d = PH_CVAL;
						clen_d  = c_base;
						if (c_base < C_LIM) begin
							wr.crypto = 1'b1;
							clen_d    = c_base + 1'b1;
						end
					end
					PH_AFIRST, PH_AVAL: begin
						phase_d = PH_AVAL;
						alen_d  = a_base;
						if (a_base < A_LIM) begin
							wr.ca  = 1'b1;
							alen_d = a_base + 1'b1;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	// hand-over of the finished string to the emitter
	assign run.go    = eos;
	assign run.value = ver_d;
	assign run.neg   = neg_d;
	assign run.ovf   = ovf_d;
	assign run_clen  = clen_d;
	assign run_alen  = alen_d;

	// parser state, back to reset after the end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			ver_q   <= 32'd0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			clen_q  <= '0;
			alen_q  <= '0;
		end else if (eos) begin
			phase_q <= PH_START;
			ver_q   <= 32'd0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			clen_q  <= '0;
			alen_q  <= '0;
		end else begin
			phase_q <= phase_d;
			ver_q   <= ver_d;
			neg_q   <= neg_d;
			ovf_q   <= ovf_d;
			clen_q  <= clen_d;
			alen_q  <= alen_d;
		end
	end

endmodule

`default_nettype wire

[rtl/apsp_emitter.sv]
`default_nettype none

module apsp_emitter
	import apsp_pkg::*;
#(
	parameter int CRYPTO_CAP = 16,
	parameter int CA_CAP = 48,
	localparam int CLEN_W = (CRYPTO_CAP > 1) ? $clog2(CRYPTO_CAP) : 1,
	localparam int ALEN_W = (CA_CAP > 1) ? $clog2(CA_CAP) : 1,
	localparam int C_DEPTH = (CRYPTO_CAP > 1) ? CRYPTO_CAP - 1 : 1,
	localparam int A_DEPTH = (CA_CAP > 1) ? CA_CAP - 1 : 1,
	localparam int C_AW = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1,
	localparam int A_AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire run_start_t        run,
	input  wire logic [CLEN_W-1:0] run_clen,
	input  wire logic [ALEN_W-1:0] run_alen,
	output logic                   busy,
	output logic                   c_re,
	output logic      [C_AW-1:0]   c_raddr,
	input  wire logic [7:0]        c_rdata,
	output logic                   a_re,
	output logic      [A_AW-1:0]   a_raddr,
	input  wire logic [7:0]        a_rdata,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [1:0]        kind,
	output logic      [31:0]       value,
	output logic                   run_end
);

	localparam int IDX_W = (CLEN_W > ALEN_W) ? CLEN_W : ALEN_W;

	logic              running_q;
	logic [1:0]        sec_q, sec_n;
	logic [IDX_W-1:0]  idx_q, idx_n, idx_inc;
	logic [CLEN_W-1:0] clen_q;
	logic [ALEN_W-1:0] alen_q;
	logic [31:0]       vval_q;
	logic              vneg_q;
	logic              vovf_q;
	logic [31:0]       ver_fin;

	logic              f_valid_q;
	logic [1:0]        f_kind_q;
	logic              f_end_q;
	logic [31:0]       f_ver_q;

	logic              consume;
	logic              issue;
	logic              stop;
	logic              c_last;
	logic              a_last;

	assign busy = running_q;

	// fetch stage moves on when the output register is free or being taken
	assign consume = f_valid_q && !(out_valid && out_stall);
	assign issue   = running_q && (!f_valid_q || consume);

	assign idx_inc = idx_q + 1'b1;
	assign c_last  = (idx_inc == IDX_W'(clen_q));
	assign a_last  = (idx_inc == IDX_W'(alen_q));

	// final version value
	assign ver_fin = vovf_q ? 32'hFFFF_FFFF : (vneg_q ? (32'd0 - vval_q) : vval_q);

	// run sequencing: version, then crypto bytes, then CA bytes
	always_comb begin
		sec_n = sec_q;
		idx_n = idx_q;
		stop  = 1'b0;
		unique case (sec_q)
			KIND_VER: begin
				idx_n = '0;
				if (clen_q != '0) begin
					sec_n = KIND_CRYPTO;
				end else if (alen_q != '0) begin
					sec_n = KIND_CA;
				end else begin
					stop = 1'b1;
				end
			end
			KIND_CRYPTO: begin
				if (c_last) begin
					idx_n = '0;
					if (alen_q != '0) begin
						sec_n = KIND_CA;
					end else begin
						stop = 1'b1;
					end
				end else begin
					idx_n = idx_inc;
				end
			end
			KIND_CA: begin
				if (a_last) begin
					stop = 1'b1;
				end else begin
					idx_n = idx_inc;
				end
			end
			default: begin
				stop = 1'b1;
			end
		endcase
	end

	assign c_re    = issue && (sec_q == KIND_CRYPTO);
	assign a_re    = issue && (sec_q == KIND_CA);
	assign c_raddr = idx_q[C_AW-1:0];
	assign a_raddr = idx_q[A_AW-1:0];

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			sec_q     <= KIND_VER;
			idx_q     <= '0;
		end else if (run.go) begin
			running_q <= 1'b1;
			sec_q     <= KIND_VER;
			idx_q     <= '0;
		end else if (issue) begin
			sec_q <= sec_n;
			idx_q <= idx_n;
			if (stop) begin
				running_q <= 1'b0;
			end
		end
	end

	// run snapshot
	always_ff @(posedge clk) begin
		if (run.go) begin
			clen_q <= run_clen;
			alen_q <= run_alen;
			vval_q <= run.value;
			vneg_q <= run.neg;
			vovf_q <= run.ovf;
		end
	end

	// fetch stage, alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_q <= 1'b0;
		end else if (issue) begin
			f_valid_q <= 1'b1;
		end else if (consume) begin
			f_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			f_kind_q <= sec_q;
			f_end_q  <= stop;
			f_ver_q  <= ver_fin;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (consume) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			kind    <= f_kind_q;
			run_end <= f_end_q;
			if (f_kind_q == KIND_VER) begin
				value <= f_ver_q;
			end else if (f_kind_q == KIND_CRYPTO) begin
				value <= {24'd0, c_rdata};
			end else begin
				value <= {24'd0, a_rdata};
			end
		end
	end

endmodule

`default_nettype wire

[rtl/auth_parms_string_parser.sv]
// parser: a character transfer is captured in the input register, then updates the parser state
// throughput: one character per cycle while in_stall is low; an end of string stalls input
//   while its run of 1 + crypto length + CA length results is read out of the stores
// output: the first result of a run goes via input, sequencer, fetch and output registers
// reset: arst_n clears parser state, lengths and handshakes at once; string stores are
//   not cleared and need no clearing pass
`default_nettype none

module auth_parms_string_parser
	import apsp_pkg::*;
#(
	parameter int CRYPTO_CAP = 16,
	parameter int CA_CAP = 48
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  ch,
	input  wire logic        has_char,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [1:0]  kind,
	output logic      [31:0] value,
	output logic             run_end
);

	localparam int CLEN_W = (CRYPTO_CAP > 1) ? $clog2(CRYPTO_CAP) : 1;
	localparam int ALEN_W = (CA_CAP > 1) ? $clog2(CA_CAP) : 1;
	localparam int C_DEPTH = (CRYPTO_CAP > 1) ? CRYPTO_CAP - 1 : 1;
	localparam int A_DEPTH = (CA_CAP > 1) ? CA_CAP - 1 : 1;
	localparam int C_AW = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
	localparam int A_AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;

	wr_en_t            wr;
	logic [C_AW-1:0]   c_waddr;
	logic [A_AW-1:0]   a_waddr;
	logic [7:0]        wdata;
	run_start_t        run;
	logic [CLEN_W-1:0] run_clen;
	logic [ALEN_W-1:0] run_alen;
	logic              busy;
	logic              c_re;
	logic [C_AW-1:0]   c_raddr;
	logic [7:0]        c_rdata;
	logic              a_re;
	logic [A_AW-1:0]   a_raddr;
	logic [7:0]        a_rdata;

	// character parser
	apsp_parser #(
		.CRYPTO_CAP(CRYPTO_CAP),
		.CA_CAP(CA_CAP)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.has_char(has_char),
		.last(last),
		.busy(busy),
		.wr(wr),
		.c_waddr(c_waddr),
		.a_waddr(a_waddr),
		.wdata(wdata),
		.run(run),
		.run_clen(run_clen),
		.run_alen(run_alen)
	);

	// crypto name store
	apsp_ram #(
		.WIDTH(8),
		.DEPTH(C_DEPTH)
	) u_crypto_ram (
		.clk(clk),
		.we(wr.crypto),
		.waddr(c_waddr),
		.wdata(wdata),
		.re(c_re),
		.raddr(c_raddr),
		.rdata(c_rdata)
	);

	// CA hash store
	apsp_ram #(
		.WIDTH(8),
		.DEPTH(A_DEPTH)
	) u_ca_ram (
		.clk(clk),
		.we(wr.ca),
		.waddr(a_waddr),
		.wdata(wdata),
		.re(a_re),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	// result run read-out
	apsp_emitter #(
		.CRYPTO_CAP(CRYPTO_CAP),
		.CA_CAP(CA_CAP)
	) u_emitter (
		.clk(clk),
		.arst_n(arst_n),
		.run(run),
		.run_clen(run_clen),
		.run_alen(run_alen),
		.busy(busy),
		.c_re(c_re),
		.c_raddr(c_raddr),
		.c_rdata(c_rdata),
		.a_re(a_re),
		.a_raddr(a_raddr),
		.a_rdata(a_rdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.value(value),
		.run_end(run_end)
	);

endmodule

`default_nettype wire

[rtl/apsp_checker.sv]
`default_nettype none

module apsp_checker
	import apsp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        last,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  kind,
	input wire logic [31:0] value,
	input wire logic        run_end
);

	logic       out_xfer;
	logic       in_xfer;
	logic       first_q;
	logic [1:0] prev_kind_q;
	logic [5:0] cnt_q;

	assign out_xfer = out_valid && !out_stall;
	assign in_xfer  = in_valid && !in_stall;

	// track position within the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= 1'b1;
			prev_kind_q <= KIND_VER;
			cnt_q       <= 6'd0;
		end else if (out_xfer) begin
			first_q     <= run_end;
			prev_kind_q <= kind;
			cnt_q       <= run_end ? 6'd0 : cnt_q + 6'd1;
		end
	end

	// a run opens with the version
	a_run_opens_ver: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && first_q) |-> (kind == KIND_VER))
		else $error("run does not open with the version");

	// inside a run only string bytes follow, crypto before CA
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && !first_q) |->
			((kind == KIND_CRYPTO && prev_kind_q != KIND_CA) || kind == KIND_CA))
		else $error("result kinds out of order within a run");

	// a run holds at most 63 results
	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (cnt_q != 6'd63))
		else $error("run longer than 63 results");

	// an end-of-string transfer blocks the input on the next cycle
	a_stall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && last) |=> in_stall)
		else $error("input not stalled after end of string");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(kind) && $stable(value) && $stable(run_end)))
		else $error("stalled result changed");

endmodule

bind auth_parms_string_parser apsp_checker u_apsp_checker (.*);

`default_nettype wire
